/* rtl/ip_address_text_validator_assert.svh */
// ----------------------------------------------------------------------------
// IP address text validator assertion macros
// Concurrent assertion wrappers that compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef IP_ADDRESS_TEXT_VALIDATOR_ASSERT_SVH
`define IP_ADDRESS_TEXT_VALIDATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define IATV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IATV_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IATV_ASSERT(lbl, prop, msg)
`define IATV_ASSERT_NR(lbl, prop, msg)
`endif

`endif

/* rtl/iatv_pkg.sv */
// ----------------------------------------------------------------------------
// IP address text validator package
// Character codes and the recognizer state record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iatv_pkg;

  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChLa    = 8'h61;
  localparam logic [7:0] ChLf    = 8'h66;
  localparam logic [7:0] ChUa    = 8'h41;
  localparam logic [7:0] ChUf    = 8'h46;

  localparam logic [1:0] V4MaxDots     = 2'd3;
  localparam logic [1:0] V4MaxDigits   = 2'd3;
  localparam logic [2:0] V6MaxDigits   = 3'd4;
  localparam logic [3:0] V6MaxGroups   = 4'd7;
  localparam logic [4:0] V6GapLimit    = 5'd6;
  localparam logic [4:0] V6GapTotalMax = 5'd6;

  typedef struct packed {
    logic       v4_failed;
    logic [1:0] v4_dots_seen;
    logic [1:0] v4_octet_digits;
    logic [7:0] v4_octet_value;
    logic       v6_failed;
    logic [2:0] v6_group_digits;
    logic [3:0] v6_groups_before_gap;
    logic [2:0] v6_groups_after_gap;
    logic       v6_gap_seen;
    logic       v6_prev_was_colon;
  } iatv_state_t;

endpackage

/* rtl/ip_address_text_validator.sv */
// ----------------------------------------------------------------------------
// IP address text validator
// Checks a character stream for dotted IPv4 or colon-hex IPv6 address text.
// ----------------------------------------------------------------------------
// The block takes one address character per beat, one beat every clock cycle
// while s_axis_tready is high, and the beat with tlast set closes the string.
// Each character updates the small recognizer state register; the closing beat
// loads the verdict into the output register, so the result beat appears in the
// cycle after the closing beat. The output register is the only stage, and the
// input is ready whenever that register is empty or being drained.
`timescale 1ns / 1ps
`include "ip_address_text_validator_assert.svh"

module ip_address_text_validator
  import iatv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic       s_axis_tlast,   // last_char
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] is_ipv4, [1] is_ipv6, [2] is_any_ip
);

  iatv_state_t st;
  iatv_state_t st_next;
  iatv_state_t cur;
  logic        at_string_start;
  logic        s_accept;
  logic        is_digit;
  logic        is_hex;
  logic [11:0] v4_sum;
  logic [4:0]  v6_cur_sum;
  logic [4:0]  v6_next_sum;
  logic        v4_ok;
  logic        v6_ok;
  logic        is_ipv4;
  logic        is_ipv6;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign cur      = at_string_start ? '0 : st;
  assign is_digit = (s_axis_tdata >= Ch0) && (s_axis_tdata <= Ch9);
  assign is_hex   = is_digit ||
                    ((s_axis_tdata >= ChLa) && (s_axis_tdata <= ChLf)) ||
                    ((s_axis_tdata >= ChUa) && (s_axis_tdata <= ChUf));
  assign v4_sum   = {1'b0, cur.v4_octet_value, 3'b000} +
                    {3'b000, cur.v4_octet_value, 1'b0} +
                    {8'd0, s_axis_tdata[3:0]};
  assign v6_cur_sum = {1'b0, cur.v6_groups_before_gap} +
                      {2'b00, cur.v6_groups_after_gap};

  always_comb begin
    st_next = cur;
    if (!cur.v4_failed) begin
      if (s_axis_tdata == ChDot) begin
        if (cur.v4_octet_digits == 2'd0 || cur.v4_dots_seen == V4MaxDots) begin
          st_next.v4_failed = 1'b1;
        end else begin
          st_next.v4_dots_seen    = cur.v4_dots_seen + 2'd1;
          st_next.v4_octet_digits = 2'd0;
          st_next.v4_octet_value  = 8'd0;
        end
      end else if (is_digit) begin
        if (cur.v4_octet_digits == V4MaxDigits || v4_sum > 12'd255) begin
          st_next.v4_failed = 1'b1;
        end else begin
          st_next.v4_octet_value  = v4_sum[7:0];
          st_next.v4_octet_digits = cur.v4_octet_digits + 2'd1;
        end
      end else begin
        st_next.v4_failed = 1'b1;
      end
    end
    if (!cur.v6_failed) begin
      if (s_axis_tdata == ChColon) begin
        if (cur.v6_prev_was_colon) begin
          if (cur.v6_gap_seen) begin
            st_next.v6_failed = 1'b1;
          end else begin
            st_next.v6_gap_seen = 1'b1;
          end
        end else if (cur.v6_group_digits == 3'd0) begin
          if (!at_string_start) begin
            st_next.v6_failed = 1'b1;
          end else begin
            st_next.v6_prev_was_colon = 1'b1;
          end
        end else begin
          if (cur.v6_gap_seen) begin
            if (v6_cur_sum >= V6GapLimit) begin
              st_next.v6_failed = 1'b1;
            end else begin
              st_next.v6_groups_after_gap = cur.v6_groups_after_gap + 3'd1;
            end
          end else begin
            if (cur.v6_groups_before_gap >= V6MaxGroups) begin
              st_next.v6_failed = 1'b1;
            end else begin
              st_next.v6_groups_before_gap = cur.v6_groups_before_gap + 4'd1;
            end
          end
          if (!st_next.v6_failed) begin
            st_next.v6_group_digits   = 3'd0;
            st_next.v6_prev_was_colon = 1'b1;
          end
        end
      end else if (is_hex) begin
        if ((cur.v6_prev_was_colon && !cur.v6_gap_seen &&
             cur.v6_groups_before_gap == 4'd0) ||
            cur.v6_group_digits >= V6MaxDigits) begin
          st_next.v6_failed = 1'b1;
        end else begin
          st_next.v6_group_digits   = cur.v6_group_digits + 3'd1;
          st_next.v6_prev_was_colon = 1'b0;
        end
      end else begin
        st_next.v6_failed = 1'b1;
      end
    end
  end

  assign v6_next_sum = {1'b0, st_next.v6_groups_before_gap} +
                       {2'b00, st_next.v6_groups_after_gap};

  assign v4_ok = !st_next.v4_failed && st_next.v4_dots_seen == V4MaxDots &&
                 st_next.v4_octet_digits != 2'd0;

  always_comb begin
    if (st_next.v6_failed) begin
      v6_ok = 1'b0;
    end else if (st_next.v6_prev_was_colon) begin
      v6_ok = st_next.v6_gap_seen && st_next.v6_groups_after_gap == 3'd0;
    end else if (st_next.v6_group_digits == 3'd0) begin
      v6_ok = 1'b0;
    end else if (!st_next.v6_gap_seen) begin
      v6_ok = st_next.v6_groups_before_gap == V6MaxGroups;
    end else if (v6_next_sum > V6GapTotalMax) begin
      v6_ok = 1'b0;
    end else begin
      v6_ok = !(st_next.v6_groups_before_gap == 4'd0 &&
                st_next.v6_groups_after_gap == 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_string_start <= 1'b1;
      st              <= '0;
    end else if (s_accept) begin
      at_string_start <= s_axis_tlast;
      st              <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_accept && s_axis_tlast) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept && s_axis_tlast) begin
      is_ipv4 <= v4_ok;
      is_ipv6 <= v6_ok;
    end
  end

  assign m_axis_tdata = {5'b00000, is_ipv4 || is_ipv6, is_ipv6, is_ipv4};

  `IATV_ASSERT(a_result_needs_close,
    (m_axis_tvalid && !$past(m_axis_tvalid)) |->
      $past(s_axis_tvalid && s_axis_tready && s_axis_tlast),
    "result beat without a closing input beat")
  `IATV_ASSERT(a_close_rearms,
    (s_accept && s_axis_tlast) |=> at_string_start,
    "string start not rearmed after closing beat")
  `IATV_ASSERT(a_not_both,
    m_axis_tvalid |-> !(is_ipv4 && is_ipv6),
    "string judged both IPv4 and IPv6")
  `IATV_ASSERT_NR(a_v6_counts,
    rst || ((st.v6_group_digits <= V6MaxDigits) &&
            (st.v6_groups_before_gap <= V6MaxGroups)),
    "IPv6 counters out of range")

endmodule
